### rtl/core/nmf_pkg.sv
// Shared types, sizes and arithmetic helpers for the NMF multiplicative update block.
// No dependencies; imported by nmf_multiplicative_update_top, nmf_ctrl, nmf_datapath and nmf_div.
`timescale 1ns / 1ps
`default_nettype none

package nmf_pkg;

    localparam int ROWS   = 8;
    localparam int COLS   = 8;
    localparam int RANK   = 4;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 20;
    localparam int ACC_W  = 48;
    localparam int ITER_W = 16;
    localparam int SIZE_W = 4;
    localparam int RANK_W = 3;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;

    localparam int I_W    = $clog2(ROWS);
    localparam int J_W    = $clog2(COLS);
    localparam int K_W    = $clog2(RANK);
    localparam int VR_AW  = $clog2(ROWS * COLS);
    localparam int W_AW   = $clog2(ROWS * RANK);
    localparam int H_AW   = $clog2(RANK * COLS);

    localparam logic [DATA_W-1:0] EPS     = 32'd10;
    localparam logic [DATA_W-1:0] ONE     = 32'h0010_0000;
    localparam logic [DATA_W-1:0] MAX_VAL = 32'hFFFF_FFFF;
    localparam logic [ITER_W-1:0] ITER_RESET = 16'd1000;

    typedef enum logic [1:0] {
        KIND_V     = 2'd0,
        KIND_W     = 2'd1,
        KIND_H     = 2'd2,
        KIND_START = 2'd3
    } kind_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_ITER = 2'd0,
        CFG_ROWS = 2'd1,
        CFG_COLS = 2'd2,
        CFG_RANK = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MAC_NONE = 3'd0,
        MAC_WH   = 3'd1,
        MAC_RH   = 3'd2,
        MAC_WR   = 3'd3,
        MAC_SUMH = 3'd4,
        MAC_SUMW = 3'd5
    } mac_t;

    typedef struct packed {
        logic [I_W-1:0]    i;
        logic [J_W-1:0]    j;
        logic [K_W-1:0]    k;
        mac_t              mac;
        logic              acc_clr;
        logic              sum_wr;
        logic              scale_ld;
        logic              scale_h;
        logic              div_go;
        logic              div_scale;
        logic              wr_v;
        logic              wr_r;
        logic              wr_w;
        logic              wr_h;
        logic              wr_load;
        logic [DATA_W-1:0] ld_value;
        logic              out_ld;
        logic              out_h;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

    function automatic logic [DATA_W-1:0] sat_acc(input logic [ACC_W:0] x);
        logic [DATA_W-1:0] r;
        if (|x[ACC_W:DATA_W]) begin
            r = MAX_VAL;
        end
        else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/nmf_if.sv
// Valid/ready channel interfaces for the load/start input and the result output.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface nmf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;

    modport source (output valid, kind, row, col, value, input ready);
    modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface nmf_out_if;
    logic        valid;
    logic        ready;
    logic        matrix_sel;
    logic [2:0]  out_row;
    logic [2:0]  out_col;
    logic [31:0] out_value;
    logic        last;

    modport source (output valid, matrix_sel, out_row, out_col, out_value, last, input ready);
    modport sink   (input valid, matrix_sel, out_row, out_col, out_value, last, output ready);
endinterface

`default_nettype wire

### rtl/core/nmf_multiplicative_update_top.sv
// Top level of the NMF multiplicative update block (KL divergence, Q12.20).
// Depends on nmf_pkg, nmf_if, nmf_ctrl and nmf_datapath.
//
//  channel   dir  handshake       beat contents
//  feed      in   valid/ready     kind, row, col, value
//  result    out  valid/ready     matrix_sel, out_row, out_col, out_value, last
//  cfg       in   cfg_we only     cfg_index, cfg_data
//
// A start beat runs each iteration, in which every ratio and every updated
// element passes through the divider, then emits W and H as result beats.
// rst_n clears control state only; the stores hold whatever was loaded.
// A stalled result beat holds the sequencer in place.
`timescale 1ns / 1ps
`default_nettype none

module nmf_multiplicative_update_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [nmf_pkg::CIDX_W-1:0] cfg_index,
    input  logic [nmf_pkg::CFG_W-1:0]  cfg_data,
    nmf_in_if.sink                     feed,
    nmf_out_if.source                  result
);
    import nmf_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    nmf_ctrl u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(feed.valid),
        .in_ready(feed.ready),
        .in_kind(feed.kind),
        .in_row(feed.row),
        .in_col(feed.col),
        .in_value(feed.value),
        .out_valid(result.valid),
        .out_ready(result.ready),
        .out_matrix_sel(result.matrix_sel),
        .out_row(result.out_row),
        .out_col(result.out_col),
        .out_last(result.last),
        .cmd(cmd),
        .stat(stat)
    );

    nmf_datapath u_datapath (
        .clk(clk),
        .rst_n(rst_n),
        .cmd(cmd),
        .stat(stat),
        .out_value(result.out_value)
    );

endmodule

`default_nettype wire

### rtl/core/nmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module nmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/nmf_div.sv
// Restoring divider, 64 by 32 bits, one quotient bit per cycle, saturating quotient.
// Depends on nmf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nmf_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2*nmf_pkg::DATA_W-1:0] dividend,
    input  logic [nmf_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic [nmf_pkg::DATA_W-1:0]   quotient
);
    import nmf_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (dividend[2*DATA_W-1:DATA_W] >= divisor)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= dividend[2*DATA_W-1:DATA_W];
            if (dividend[2*DATA_W-1:DATA_W] >= divisor)
            begin
                quo_reg <= MAX_VAL;
            end
            else
            begin
                quo_reg <= dividend[DATA_W-1:0];
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DATA_W'(trial - {1'b0, dvs_reg}) : trial[DATA_W-1:0];
            quo_reg <= {quo_reg[DATA_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### rtl/core/nmf_datapath.sv
// Datapath: V, W, H and ratio RAMs, shared multiplier, accumulator, per-rank sums of W or H, divider.
// Depends on nmf_pkg, nmf_ram and nmf_div.
`timescale 1ns / 1ps
`default_nettype none

module nmf_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  nmf_pkg::cmd_t              cmd,
    output nmf_pkg::stat_t             stat,
    output logic [nmf_pkg::DATA_W-1:0] out_value
);
    import nmf_pkg::*;

    logic [VR_AW-1:0]    vr_addr;
    logic [W_AW-1:0]     w_addr;
    logic [H_AW-1:0]     h_addr;
    logic [DATA_W-1:0]   wr_data;
    logic [DATA_W-1:0]   v_q, r_q, w_q, h_q;
    logic [DATA_W-1:0]   quo;
    logic [DATA_W-1:0]   mul_a, mul_b;
    logic [2*DATA_W-1:0] mul_full;
    logic [DATA_W-1:0]   acc_sat, acc_eps;
    logic [2*DATA_W-1:0] div_dvd;
    logic [DATA_W-1:0]   div_dvs;

    mac_t                m1_reg;
    logic                v2_reg;
    logic [2*DATA_W-1:0] prod_reg;
    logic [2*DATA_W-1:0] scale_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [ACC_W-1:0]    acc_next;
    logic [DATA_W-1:0]   sum_reg [RANK];
    logic [DATA_W-1:0]   out_reg;

    assign vr_addr = VR_AW'(cmd.i) * VR_AW'(COLS) + VR_AW'(cmd.j);
    assign w_addr  = W_AW'(cmd.i) * W_AW'(RANK) + W_AW'(cmd.k);
    assign h_addr  = H_AW'(cmd.k) * H_AW'(COLS) + H_AW'(cmd.j);
    assign wr_data = cmd.wr_load ? cmd.ld_value : quo;

    nmf_ram #(.WIDTH(DATA_W), .DEPTH(ROWS * COLS)) u_v_ram (
        .clk(clk), .we(cmd.wr_v), .waddr(vr_addr), .wdata(wr_data),
        .raddr(vr_addr), .rdata(v_q)
    );

    nmf_ram #(.WIDTH(DATA_W), .DEPTH(ROWS * COLS)) u_r_ram (
        .clk(clk), .we(cmd.wr_r), .waddr(vr_addr), .wdata(wr_data),
        .raddr(vr_addr), .rdata(r_q)
    );

    nmf_ram #(.WIDTH(DATA_W), .DEPTH(ROWS * RANK)) u_w_ram (
        .clk(clk), .we(cmd.wr_w), .waddr(w_addr), .wdata(wr_data),
        .raddr(w_addr), .rdata(w_q)
    );

    nmf_ram #(.WIDTH(DATA_W), .DEPTH(RANK * COLS)) u_h_ram (
        .clk(clk), .we(cmd.wr_h), .waddr(h_addr), .wdata(wr_data),
        .raddr(h_addr), .rdata(h_q)
    );

    assign acc_sat = sat_acc({1'b0, acc_reg});
    assign acc_eps = sat_acc({1'b0, acc_reg} + (ACC_W + 1)'(EPS));

    always_comb
    begin
        mul_a = w_q;
        mul_b = h_q;
        if (cmd.scale_ld)
        begin
            mul_a = cmd.scale_h ? h_q : w_q;
            mul_b = acc_sat;
        end
        else
        begin
            unique case (m1_reg)
                MAC_WH:   begin mul_a = w_q; mul_b = h_q; end
                MAC_RH:   begin mul_a = r_q; mul_b = h_q; end
                MAC_WR:   begin mul_a = w_q; mul_b = r_q; end
                MAC_SUMH: begin mul_a = h_q; mul_b = ONE; end
                MAC_SUMW: begin mul_a = w_q; mul_b = ONE; end
                default:  begin mul_a = w_q; mul_b = h_q; end
            endcase
        end
    end

    assign mul_full = (2 * DATA_W)'(mul_a) * (2 * DATA_W)'(mul_b);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.acc_clr)
        begin
            acc_next = '0;
        end
        else if (v2_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg[2*DATA_W-1:FRAC_W]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg <= MAC_NONE;
            v2_reg <= 1'b0;
        end
        else
        begin
            m1_reg <= cmd.mac;
            v2_reg <= (m1_reg != MAC_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_full;
        acc_reg  <= acc_next;
        if (cmd.scale_ld)
        begin
            scale_reg <= mul_full;
        end
        if (cmd.sum_wr)
        begin
            sum_reg[cmd.k] <= acc_eps;
        end
        if (cmd.out_ld)
        begin
            out_reg <= cmd.out_h ? h_q : w_q;
        end
    end

    assign div_dvd = cmd.div_scale ? scale_reg
                                   : {(DATA_W - FRAC_W)'(0), v_q, FRAC_W'(0)};
    assign div_dvs = cmd.div_scale ? sum_reg[cmd.k] : acc_eps;

    nmf_div u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_go),
        .dividend(div_dvd), .divisor(div_dvs),
        .done(stat.div_done), .quotient(quo)
    );

    assign out_value = out_reg;

endmodule

`default_nettype wire

### rtl/core/nmf_ctrl.sv
// Controller: configuration registers, load decode and the update/emit sequencer.
// Depends on nmf_pkg; drives nmf_datapath through cmd_t and reads stat_t.
`timescale 1ns / 1ps
`default_nettype none

module nmf_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [nmf_pkg::CIDX_W-1:0] cfg_index,
    input  logic [nmf_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 in_kind,
    input  logic [2:0]                 in_row,
    input  logic [2:0]                 in_col,
    input  logic [nmf_pkg::DATA_W-1:0] in_value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       out_matrix_sel,
    output logic [2:0]                 out_row,
    output logic [2:0]                 out_col,
    output logic                       out_last,
    output nmf_pkg::cmd_t              cmd,
    input  nmf_pkg::stat_t             stat
);
    import nmf_pkg::*;

    typedef enum logic [15:0] {
        ST_IDLE    = 16'h0001,
        ST_R_MAC   = 16'h0002,
        ST_R_DRAIN = 16'h0004,
        ST_R_DIVGO = 16'h0008,
        ST_R_DIVW  = 16'h0010,
        ST_D_MAC   = 16'h0020,
        ST_D_DRAIN = 16'h0040,
        ST_D_FIN   = 16'h0080,
        ST_U_MAC   = 16'h0100,
        ST_U_DRAIN = 16'h0200,
        ST_U_SCALE = 16'h0400,
        ST_U_DIVGO = 16'h0800,
        ST_U_DIVW  = 16'h1000,
        ST_E_RD    = 16'h2000,
        ST_E_LD    = 16'h4000,
        ST_E_OUT   = 16'h8000
    } state_t;

    state_t            state_reg, state_next;
    logic [ITER_W-1:0] iter_reg;
    logic [SIZE_W-1:0] rows_reg, cols_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [ITER_W-1:0] it_reg, it_next;
    logic [I_W-1:0]    i_reg, i_next;
    logic [J_W-1:0]    j_reg, j_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic              hph_reg, hph_next;
    logic              esel_reg, esel_next;
    logic              drain_reg, drain_next;
    logic              ov_reg, ov_next;
    logic              sel_reg, sel_next;
    logic [2:0]        row_reg, row_next;
    logic [2:0]        col_reg, col_next;
    logic              last_reg, last_next;

    logic [SIZE_W-1:0] nr, nc;
    logic [RANK_W-1:0] nk;
    logic              i_last, j_last, k_last;

    always_comb
    begin
        priority if (rows_reg == '0)                 nr = SIZE_W'(1);
        else if (rows_reg > SIZE_W'(ROWS))           nr = SIZE_W'(ROWS);
        else                                         nr = rows_reg;
        priority if (cols_reg == '0)                 nc = SIZE_W'(1);
        else if (cols_reg > SIZE_W'(COLS))           nc = SIZE_W'(COLS);
        else                                         nc = cols_reg;
        priority if (rank_reg == '0)                 nk = RANK_W'(1);
        else if (rank_reg > RANK_W'(RANK))           nk = RANK_W'(RANK);
        else                                         nk = rank_reg;
    end

    assign i_last = (i_reg == I_W'(nr - SIZE_W'(1)));
    assign j_last = (j_reg == J_W'(nc - SIZE_W'(1)));
    assign k_last = (k_reg == K_W'(nk - RANK_W'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= ITER_RESET;
            rows_reg <= SIZE_W'(ROWS);
            cols_reg <= SIZE_W'(COLS);
            rank_reg <= RANK_W'(RANK);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ITER: iter_reg <= cfg_data[ITER_W-1:0];
                CFG_ROWS: rows_reg <= cfg_data[SIZE_W-1:0];
                CFG_COLS: cols_reg <= cfg_data[SIZE_W-1:0];
                CFG_RANK: rank_reg <= cfg_data[RANK_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        hph_next   = hph_reg;
        esel_next  = esel_reg;
        drain_next = drain_reg;
        ov_next    = ov_reg;
        sel_next   = sel_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;

        cmd          = '0;
        cmd.mac      = MAC_NONE;
        cmd.i        = i_reg;
        cmd.j        = j_reg;
        cmd.k        = k_reg;
        cmd.ld_value = in_value;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.wr_load = 1'b1;
                if (in_valid)
                begin
                    unique case (kind_t'(in_kind))
                        KIND_V:
                        begin
                            if ({1'b0, in_row} < nr && {1'b0, in_col} < nc)
                            begin
                                cmd.wr_v = 1'b1;
                                cmd.i    = I_W'(in_row);
                                cmd.j    = J_W'(in_col);
                            end
                        end
                        KIND_W:
                        begin
                            if ({1'b0, in_row} < nr && in_col < nk)
                            begin
                                cmd.wr_w = 1'b1;
                                cmd.i    = I_W'(in_row);
                                cmd.k    = K_W'(in_col);
                            end
                        end
                        KIND_H:
                        begin
                            if (in_row < nk && {1'b0, in_col} < nc)
                            begin
                                cmd.wr_h = 1'b1;
                                cmd.k    = K_W'(in_row);
                                cmd.j    = J_W'(in_col);
                            end
                        end
                        KIND_START:
                        begin
                            it_next    = iter_reg;
                            i_next     = '0;
                            j_next     = '0;
                            k_next     = '0;
                            hph_next   = 1'b0;
                            esel_next  = 1'b0;
                            drain_next = 1'b0;
                            state_next = (iter_reg == '0) ? ST_E_RD : ST_R_MAC;
                        end
                    endcase
                end
            end

            ST_R_MAC:
            begin
                cmd.mac     = MAC_WH;
                cmd.acc_clr = (k_reg == '0);
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_R_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            ST_R_DRAIN:
            begin
                drain_next = ~drain_reg;
                if (drain_reg)
                begin
                    state_next = ST_R_DIVGO;
                end
            end

            ST_R_DIVGO:
            begin
                cmd.div_go = 1'b1;
                state_next = ST_R_DIVW;
            end

            ST_R_DIVW:
            begin
                if (stat.div_done)
                begin
                    cmd.wr_r   = 1'b1;
                    state_next = ST_R_MAC;
                    if (j_last)
                    begin
                        j_next = '0;
                        if (i_last)
                        begin
                            i_next     = '0;
                            state_next = ST_D_MAC;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end

            ST_D_MAC:
            begin
                if (hph_reg)
                begin
                    cmd.mac     = MAC_SUMW;
                    cmd.acc_clr = (i_reg == '0);
                    if (i_last)
                    begin
                        i_next     = '0;
                        state_next = ST_D_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.mac     = MAC_SUMH;
                    cmd.acc_clr = (j_reg == '0);
                    if (j_last)
                    begin
                        j_next     = '0;
                        state_next = ST_D_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end

            ST_D_DRAIN:
            begin
                drain_next = ~drain_reg;
                if (drain_reg)
                begin
                    state_next = ST_D_FIN;
                end
            end

            ST_D_FIN:
            begin
                cmd.sum_wr = 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_U_MAC;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_D_MAC;
                end
            end

            ST_U_MAC:
            begin
                if (hph_reg)
                begin
                    cmd.mac     = MAC_WR;
                    cmd.acc_clr = (i_reg == '0);
                    if (i_last)
                    begin
                        i_next     = '0;
                        state_next = ST_U_DRAIN;
                    end
                    else
                    begin
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    cmd.mac     = MAC_RH;
                    cmd.acc_clr = (j_reg == '0);
                    if (j_last)
                    begin
                        j_next     = '0;
                        state_next = ST_U_DRAIN;
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end

            ST_U_DRAIN:
            begin
                drain_next = ~drain_reg;
                if (drain_reg)
                begin
                    state_next = ST_U_SCALE;
                end
            end

            ST_U_SCALE:
            begin
                cmd.scale_ld = 1'b1;
                cmd.scale_h  = hph_reg;
                state_next   = ST_U_DIVGO;
            end

            ST_U_DIVGO:
            begin
                cmd.div_go    = 1'b1;
                cmd.div_scale = 1'b1;
                state_next    = ST_U_DIVW;
            end

            ST_U_DIVW:
            begin
                cmd.div_scale = 1'b1;
                if (stat.div_done)
                begin
                    cmd.wr_w   = ~hph_reg;
                    cmd.wr_h   = hph_reg;
                    state_next = ST_U_MAC;
                    if (!hph_reg)
                    begin
                        if (k_last)
                        begin
                            k_next = '0;
                            if (i_last)
                            begin
                                i_next     = '0;
                                hph_next   = 1'b1;
                                state_next = ST_R_MAC;
                            end
                            else
                            begin
                                i_next = i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (j_last)
                        begin
                            j_next = '0;
                            if (k_last)
                            begin
                                k_next   = '0;
                                hph_next = 1'b0;
                                it_next  = it_reg - 1'b1;
                                state_next = (it_reg == ITER_W'(1)) ? ST_E_RD : ST_R_MAC;
                            end
                            else
                            begin
                                k_next = k_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end

            ST_E_RD:
            begin
                state_next = ST_E_LD;
            end

            ST_E_LD:
            begin
                cmd.out_ld = 1'b1;
                cmd.out_h  = esel_reg;
                ov_next    = 1'b1;
                sel_next   = esel_reg;
                row_next   = esel_reg ? 3'(k_reg) : 3'(i_reg);
                col_next   = esel_reg ? 3'(j_reg) : 3'(k_reg);
                last_next  = esel_reg & k_last & j_last;
                state_next = ST_E_OUT;
            end

            ST_E_OUT:
            begin
                if (out_ready)
                begin
                    ov_next    = 1'b0;
                    state_next = ST_E_RD;
                    if (!esel_reg)
                    begin
                        if (k_last)
                        begin
                            k_next = '0;
                            if (i_last)
                            begin
                                i_next    = '0;
                                esel_next = 1'b1;
                            end
                            else
                            begin
                                i_next = i_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (j_last)
                        begin
                            j_next = '0;
                            if (k_last)
                            begin
                                k_next     = '0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                k_next = k_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            it_reg    <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            hph_reg   <= 1'b0;
            esel_reg  <= 1'b0;
            drain_reg <= 1'b0;
            ov_reg    <= 1'b0;
            sel_reg   <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            it_reg    <= it_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            hph_reg   <= hph_next;
            esel_reg  <= esel_next;
            drain_reg <= drain_next;
            ov_reg    <= ov_next;
            sel_reg   <= sel_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid      = ov_reg;
    assign out_matrix_sel = sel_reg;
    assign out_row        = row_reg;
    assign out_col        = col_reg;
    assign out_last       = last_reg;

    a_out_only_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (state_reg == ST_E_OUT))
        else $error("result beat offered outside the emit state");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> (state_reg == ST_R_DIVW || state_reg == ST_U_DIVW))
        else $error("divider finished with no step waiting for it");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_load && (cmd.wr_v || cmd.wr_w || cmd.wr_h)) |-> (state_reg == ST_IDLE))
        else $error("load write issued while a run is in progress");

    a_emit_loads_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E_LD) |=> ov_reg)
        else $error("emit step did not present a result beat");

endmodule

`default_nettype wire
